// ----- src/ipv4rx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipv4rx_pkg;

    localparam logic [15:0] MIN_HEADER_BYTES = 16'd20;
    localparam logic [15:0] WORD_MASK        = 16'hFFFF;
    localparam logic [31:0] BROADCAST_ADDR   = 32'hFFFF_FFFF;
    localparam logic [3:0]  IP_VERSION_4     = 4'd4;
    localparam logic [3:0]  MIN_IHL_WORDS    = 4'd5;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;

    // header byte positions
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_TLEN_HI  = 16'd2;
    localparam logic [15:0] POS_TLEN_LO  = 16'd3;
    localparam logic [15:0] POS_FRAG_HI  = 16'd6;
    localparam logic [15:0] POS_FRAG_LO  = 16'd7;
    localparam logic [15:0] POS_PROTOCOL = 16'd9;
    localparam logic [15:0] POS_SRC_0    = 16'd12;
    localparam logic [15:0] POS_SRC_1    = 16'd13;
    localparam logic [15:0] POS_SRC_2    = 16'd14;
    localparam logic [15:0] POS_SRC_3    = 16'd15;
    localparam logic [15:0] POS_DST_0    = 16'd16;
    localparam logic [15:0] POS_DST_1    = 16'd17;
    localparam logic [15:0] POS_DST_2    = 16'd18;
    localparam logic [15:0] POS_DST_3    = 16'd19;

    typedef enum logic [3:0] {
        VERDICT_TCP        = 4'd0,
        VERDICT_UDP        = 4'd1,
        VERDICT_OTHER      = 4'd2,
        VERDICT_SHORT      = 4'd3,
        VERDICT_BAD_VER    = 4'd4,
        VERDICT_HDR_LONG   = 4'd5,
        VERDICT_CHECKSUM   = 4'd6,
        VERDICT_NOT_OURS   = 4'd7,
        VERDICT_FRAGMENT   = 4'd8,
        VERDICT_TOTAL_LONG = 4'd9,
        VERDICT_TOTAL_SHORT = 4'd10
    } verdict_t;

    // frame state as it stands after the current beat
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [15:0] sum;
        logic [15:0] total_length;
        logic        offset_nonzero;
        logic [7:0]  protocol;
        logic [31:0] source;
        logic [31:0] destination;
        logic [15:0] frame_len;
    } hdr_view_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] payload_length;
    } result_t;

    function automatic result_t classify(hdr_view_t v, logic [31:0] my_addr);
        result_t     r;
        logic [15:0] hdr_len;
        hdr_len          = {10'd0, v.header_words, 2'b00};
        r.payload_length = '0;
        if (v.frame_len < MIN_HEADER_BYTES)
            r.verdict = VERDICT_SHORT;
        else if (v.version != IP_VERSION_4 || v.header_words < MIN_IHL_WORDS)
            r.verdict = VERDICT_BAD_VER;
        else if (v.frame_len < hdr_len)
            r.verdict = VERDICT_HDR_LONG;
        else if (v.sum != WORD_MASK)
            r.verdict = VERDICT_CHECKSUM;
        else if (v.destination != my_addr && v.destination != BROADCAST_ADDR)
            r.verdict = VERDICT_NOT_OURS;
        else if (v.offset_nonzero)
            r.verdict = VERDICT_FRAGMENT;
        else if (v.total_length > v.frame_len)
            r.verdict = VERDICT_TOTAL_LONG;
        else if (v.total_length < hdr_len)
            r.verdict = VERDICT_TOTAL_SHORT;
        else
        begin
            r.payload_length = v.total_length - hdr_len;
            if (v.protocol == PROTO_TCP)
                r.verdict = VERDICT_TCP;
            else if (v.protocol == PROTO_UDP)
                r.verdict = VERDICT_UDP;
            else
                r.verdict = VERDICT_OTHER;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/ipv4_receive_header_filter.sv -----
// order: an accepted byte beat is held in the input register and processed from there;
//   the verdict of a last beat is then registered in the result register and driven out
// throughput: one byte per cycle; the input register keeps taking beats while a
//   verdict waits, and stalls only when a second last beat meets a full result register
// reset: rst_n clears the frame state, my_address and both valid flags at once
`timescale 1ns / 1ps
`default_nettype none

module ipv4_receive_header_filter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       verdict,
    output logic [31:0]      source_address,
    output logic [5:0]       payload_offset,
    output logic [15:0]      payload_length
);
    import ipv4rx_pkg::*;

    logic [31:0] my_addr_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic [3:0]  verdict_reg;
    logic [31:0] source_reg;
    logic [5:0]  offset_reg;
    logic [15:0] plen_reg;

    logic        proceed;
    hdr_view_t   view;
    result_t     res;

    assign cfg_ready = 1'b1;

    // a last beat needs a free result slot, other beats always go through
    assign proceed  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || proceed;

    ipv4rx_hdr_track u_hdr_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (proceed),
        .frame_byte (byte_reg),
        .last       (last_reg),
        .view       (view)
    );

    assign res = classify(view, my_addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_addr_reg   <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                my_addr_reg <= cfg_data;
            if (in_ready)
                in_valid_reg <= in_valid;
            if (proceed && last_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= frame_byte;
            last_reg <= last;
        end
        if (proceed && last_reg)
        begin
            verdict_reg <= res.verdict;
            source_reg  <= view.source;
            offset_reg  <= {view.header_words, 2'b00};
            plen_reg    <= res.payload_length;
        end
    end

    assign out_valid      = out_valid_reg;
    assign verdict        = verdict_reg;
    assign source_address = source_reg;
    assign payload_offset = offset_reg;
    assign payload_length = plen_reg;

endmodule

`default_nettype wire

// ----- src/ipv4rx_hdr_track.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_hdr_track (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            frame_byte,
    input  wire logic                  last,
    output ipv4rx_pkg::hdr_view_t      view
);
    import ipv4rx_pkg::*;

    logic [15:0] count_reg,  count_next;
    logic [3:0]  ver_reg,    ver_next;
    logic [3:0]  hw_reg,     hw_next;
    logic [15:0] sum_reg,    sum_next;
    logic [7:0]  hold_reg,   hold_next;
    logic [15:0] tlen_reg,   tlen_next;
    logic        off_reg,    off_next;
    logic [7:0]  proto_reg,  proto_next;
    logic [31:0] src_reg,    src_next;
    logic [31:0] dst_reg,    dst_next;

    logic [5:0]  hdr_len;
    logic        in_hdr;
    logic [16:0] raw_sum;
    logic [15:0] wrap_sum;

    always_comb
    begin
        ver_next   = ver_reg;
        hw_next    = hw_reg;
        tlen_next  = tlen_reg;
        off_next   = off_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        case (count_reg)
            POS_VER_IHL:
            begin
                ver_next = frame_byte[7:4];
                hw_next  = frame_byte[3:0];
            end
            POS_TLEN_HI:  tlen_next[15:8] = frame_byte;
            POS_TLEN_LO:  tlen_next[7:0]  = frame_byte;
            // only the low five bits of the high byte belong to the offset
            POS_FRAG_HI:  off_next = off_reg | (frame_byte[4:0] != 5'd0);
            POS_FRAG_LO:  off_next = off_reg | (frame_byte != 8'd0);
            POS_PROTOCOL: proto_next = frame_byte;
            POS_SRC_0:    src_next[31:24] = frame_byte;
            POS_SRC_1:    src_next[23:16] = frame_byte;
            POS_SRC_2:    src_next[15:8]  = frame_byte;
            POS_SRC_3:    src_next[7:0]   = frame_byte;
            POS_DST_0:    dst_next[31:24] = frame_byte;
            POS_DST_1:    dst_next[23:16] = frame_byte;
            POS_DST_2:    dst_next[15:8]  = frame_byte;
            POS_DST_3:    dst_next[7:0]   = frame_byte;
            default:      ;
        endcase

        hdr_len  = {hw_next, 2'b00};
        in_hdr   = count_reg < {10'd0, hdr_len};
        raw_sum  = {1'b0, sum_reg} + {1'b0, hold_reg, frame_byte};
        // end-around carry, never overflows again
        wrap_sum = raw_sum[15:0] + {15'd0, raw_sum[16]};

        hold_next = (in_hdr && !count_reg[0]) ? frame_byte : hold_reg;
        sum_next  = (in_hdr && count_reg[0]) ? wrap_sum : sum_reg;
        count_next = (count_reg == WORD_MASK) ? count_reg : count_reg + 16'd1;

        view.version        = ver_next;
        view.header_words   = hw_next;
        view.sum            = sum_next;
        view.total_length   = tlen_next;
        view.offset_nonzero = off_next;
        view.protocol       = proto_next;
        view.source         = src_next;
        view.destination    = dst_next;
        view.frame_len      = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ver_reg   <= '0;
            hw_reg    <= '0;
            sum_reg   <= '0;
            hold_reg  <= '0;
            tlen_reg  <= '0;
            off_reg   <= 1'b0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else if (step)
        begin
            if (last)
            begin
                count_reg <= '0;
                ver_reg   <= '0;
                hw_reg    <= '0;
                sum_reg   <= '0;
                hold_reg  <= '0;
                tlen_reg  <= '0;
                off_reg   <= 1'b0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                ver_reg   <= ver_next;
                hw_reg    <= hw_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                tlen_reg  <= tlen_next;
                off_reg   <= off_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/ipv4rx_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipv4rx_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [3:0]  verdict,
    input wire logic [5:0]  payload_offset,
    input wire logic [15:0] payload_length
);
    import ipv4rx_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(payload_length))
        else $error("result beat changed while stalled");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> verdict <= VERDICT_TOTAL_SHORT)
        else $error("verdict code out of range");

    a_drop_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict >= VERDICT_SHORT |-> payload_length == 16'd0)
        else $error("dropped frame carries a payload length");

    // a delivered frame passed the ihl check
    a_deliver_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (verdict == VERDICT_TCP || verdict == VERDICT_UDP
            || verdict == VERDICT_OTHER) |-> payload_offset >= 6'd20)
        else $error("delivered frame with short header");

    a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> payload_offset[1:0] == 2'b00)
        else $error("payload offset not a word multiple");

endmodule

bind ipv4_receive_header_filter ipv4rx_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .verdict        (verdict),
    .payload_offset (payload_offset),
    .payload_length (payload_length)
);

`default_nettype wire

// ----- sim/ipv4_verdict_checker.sv -----
`timescale 1ns / 1ps

module ipv4_verdict_checker
    import ipv4rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  verdict,
    input  logic [31:0] source_address,
    input  logic [5:0]  payload_offset,
    input  logic [15:0] payload_length,
    output int          error_count,
    output int          results_pending,
    output int          beats_seen,
    output int          verdicts_seen,
    output logic [15:0] verdicts_hit
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        verdict_t    code;
        logic [31:0] source;
        logic [5:0]  offset;
        logic [15:0] plen;
    } ip_verdict_t;

    ip_verdict_t verdict_q[$];

    // shadow of the frame parser
    logic [31:0] own_addr;
    logic [15:0] rx_count;
    logic [3:0]  ver_nib;
    logic [3:0]  ihl_nib;
    logic [15:0] csum_acc;
    logic [7:0]  hi_hold;
    logic [15:0] tot_len;
    logic        frag_seen;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;

    int          errors;
    int          reported;
    int          beats;
    int          verdicts;
    logic [15:0] hits;

    task automatic clear_frame();
        rx_count  = '0;
        ver_nib   = '0;
        ihl_nib   = '0;
        csum_acc  = '0;
        hi_hold   = '0;
        tot_len   = '0;
        frag_seen = 1'b0;
        proto     = '0;
        src_addr  = '0;
        dst_addr  = '0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic lst);
        logic [15:0] pos;
        logic [15:0] hlen;
        logic [16:0] s;
        int          slot;
        ip_verdict_t e;
        pos = rx_count;
        if (pos == POS_VER_IHL)
        begin
            ver_nib = b[7:4];
            ihl_nib = b[3:0];
        end
        else if (pos == POS_TLEN_HI)
            tot_len[15:8] = b;
        else if (pos == POS_TLEN_LO)
            tot_len[7:0] = b;
        else if (pos == POS_FRAG_HI)
        begin
            // flag bits sit above the 13-bit offset
            if (b[4:0] != 5'd0)
                frag_seen = 1'b1;
        end
        else if (pos == POS_FRAG_LO)
        begin
            if (b != 8'd0)
                frag_seen = 1'b1;
        end
        else if (pos == POS_PROTOCOL)
            proto = b;
        else if (pos >= POS_SRC_0 && pos <= POS_SRC_3)
        begin
            slot = int'(pos - POS_SRC_0);
            src_addr[(3 - slot) * 8 +: 8] = b;
        end
        else if (pos >= POS_DST_0 && pos <= POS_DST_3)
        begin
            slot = int'(pos - POS_DST_0);
            dst_addr[(3 - slot) * 8 +: 8] = b;
        end

        hlen = {10'd0, ihl_nib, 2'b00};
        if (pos < hlen)
        begin
            if (!pos[0])
                hi_hold = b;
            else
            begin
                s = {1'b0, csum_acc} + {1'b0, hi_hold, b};
                csum_acc = s[16] ? s[15:0] + 16'd1 : s[15:0];
            end
        end

        if (rx_count != WORD_MASK)
            rx_count = rx_count + 16'd1;

        if (lst)
        begin
            e.source = src_addr;
            e.offset = hlen[5:0];
            e.plen   = '0;
            if (rx_count < MIN_HEADER_BYTES)
                e.code = VERDICT_SHORT;
            else if (ver_nib != IP_VERSION_4 || ihl_nib < MIN_IHL_WORDS)
                e.code = VERDICT_BAD_VER;
            else if (rx_count < hlen)
                e.code = VERDICT_HDR_LONG;
            else if (csum_acc != WORD_MASK)
                e.code = VERDICT_CHECKSUM;
            else if (dst_addr != own_addr && dst_addr != BROADCAST_ADDR)
                e.code = VERDICT_NOT_OURS;
            else if (frag_seen)
                e.code = VERDICT_FRAGMENT;
            else if (tot_len > rx_count)
                e.code = VERDICT_TOTAL_LONG;
            else if (tot_len < hlen)
                e.code = VERDICT_TOTAL_SHORT;
            else
            begin
                e.plen = tot_len - hlen;
                if (proto == PROTO_TCP)
                    e.code = VERDICT_TCP;
                else if (proto == PROTO_UDP)
                    e.code = VERDICT_UDP;
                else
                    e.code = VERDICT_OTHER;
            end
            verdict_q.push_back(e);
            hits[e.code] = 1'b1;
            clear_frame();
        end
    endtask

    task automatic check_verdict();
        ip_verdict_t e;
        verdicts++;
        if (verdict_q.size() == 0)
        begin
            errors++;
            if (reported < REPORT_LIMIT)
            begin
                reported++;
                $display("[%0t] unexpected verdict beat: verdict %0d src %h offset %0d len %0d",
                         $realtime, verdict, source_address, payload_offset, payload_length);
            end
        end
        else
        begin
            e = verdict_q.pop_front();
            if (verdict !== e.code || source_address !== e.source ||
                payload_offset !== e.offset || payload_length !== e.plen)
            begin
                errors++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("[%0t] verdict mismatch: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                             $realtime, e.code, e.source, e.offset, e.plen,
                             verdict, source_address, payload_offset, payload_length);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_q.delete();
            clear_frame();
            own_addr = '0;
            errors   = 0;
            reported = 0;
            beats    = 0;
            verdicts = 0;
            hits     = '0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_verdict();
            if (cfg_valid && cfg_ready)
                own_addr = cfg_data;
            if (in_valid && in_ready)
            begin
                beats++;
                take_byte(frame_byte, last);
            end
        end
        error_count     <= errors;
        results_pending <= verdict_q.size();
        beats_seen      <= beats;
        verdicts_seen   <= verdicts;
        verdicts_hit    <= hits;
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ipv4rx_pkg::*;

    localparam int PHASES         = 5;
    localparam int PHASE_BYTES    = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_e;

    typedef enum int {
        FRAME_GOOD,
        FRAME_SHORT,
        FRAME_BAD_VER,
        FRAME_HDR_LONG,
        FRAME_BAD_SUM,
        FRAME_NOT_OURS,
        FRAME_FRAGMENT,
        FRAME_TOTAL_LONG,
        FRAME_TOTAL_SHORT,
        FRAME_NOISE,
        FRAME_MAX_IHL
    } frame_kind_e;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  frame_byte;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  verdict;
    logic [31:0] source_address;
    logic [5:0]  payload_offset;
    logic [15:0] payload_length;

    int          check_errors;
    int          results_pending;
    int          beats_seen;
    int          verdicts_seen;
    logic [15:0] verdicts_hit;

    rx_mode_e    rx_mode;
    logic        hold_request;
    bit          tx_gappy;
    int          burst_left;
    int          cfg_writes;
    int          idle_cycles;
    logic [31:0] cur_addr;
    logic [7:0]  pkt[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ipv4_receive_header_filter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_byte     (frame_byte),
        .last           (last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .verdict        (verdict),
        .source_address (source_address),
        .payload_offset (payload_offset),
        .payload_length (payload_length)
    );

    ipv4_verdict_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .frame_byte      (frame_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .verdict         (verdict),
        .source_address  (source_address),
        .payload_offset  (payload_offset),
        .payload_length  (payload_length),
        .error_count     (check_errors),
        .results_pending (results_pending),
        .beats_seen      (beats_seen),
        .verdicts_seen   (verdicts_seen),
        .verdicts_hit    (verdicts_hit)
    );

    // receiver side: stall pattern per mode, plus one long hold-off on request
    initial
    begin
        bit         hold_served;
        logic [7:0] rx_pattern;
        hold_served = 1'b0;
        rx_pattern  = 8'b1101_0110;
        out_ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  out_ready <= ($urandom_range(0, 5) == 0);
                    default:
                    begin
                        out_ready  <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = tx_gappy ? $urandom_range(1, 5) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        frame_byte <= b;
        last       <= lst;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_frame();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // header checksum over the first hdr bytes, checksum field taken as zero
    task automatic seal_header(input int hdr);
        logic [15:0] acc;
        logic [16:0] s;
        acc     = '0;
        pkt[10] = 8'd0;
        pkt[11] = 8'd0;
        for (int i = 0; i < hdr; i += 2)
        begin
            s   = {1'b0, acc} + {1'b0, pkt[i], pkt[i + 1]};
            acc = s[15:0] + 16'(s[16]);
        end
        pkt[10] = ~acc[15:8];
        pkt[11] = ~acc[7:0];
    endtask

    task automatic build_frame(input frame_kind_e kind);
        int          ihl;
        int          hdr;
        int          flen;
        int          tot;
        int          cut;
        int          idx;
        logic [7:0]  b0;
        logic [31:0] dst;
        pkt.delete();
        if (kind == FRAME_NOISE)
        begin
            cut = $urandom_range(1, 48);
            for (int i = 0; i < cut; i++)
                pkt.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                pkt[0] = {IP_VERSION_4, MIN_IHL_WORDS};
        end
        else
        begin
            if (kind == FRAME_MAX_IHL)
                ihl = 15;
            else if (kind == FRAME_HDR_LONG || $urandom_range(0, 3) == 0)
                ihl = $urandom_range(6, 15);
            else
                ihl = 5;
            hdr  = ihl * 4;
            flen = hdr + $urandom_range(0, 16);
            tot  = $urandom_range(0, 1) ? flen : $urandom_range(hdr, flen);
            if (kind == FRAME_TOTAL_LONG)
                tot = flen + $urandom_range(1, 200);
            else if (kind == FRAME_TOTAL_SHORT)
                tot = $urandom_range(0, hdr - 1);
            for (int i = 0; i < flen; i++)
                pkt.push_back(8'($urandom_range(0, 255)));
            pkt[0] = {IP_VERSION_4, 4'(ihl)};
            pkt[2] = 8'(tot >> 8);
            pkt[3] = 8'(tot);
            pkt[6] = {pkt[6][7:5], 5'd0};
            pkt[7] = 8'd0;
            case ($urandom_range(0, 2))
                0:       pkt[9] = PROTO_TCP;
                1:       pkt[9] = PROTO_UDP;
                default: pkt[9] = 8'($urandom_range(0, 255));
            endcase
            if (kind == FRAME_NOT_OURS)
                dst = $urandom;
            else if ($urandom_range(0, 3) == 0)
                dst = BROADCAST_ADDR;
            else
                dst = cur_addr;
            for (int i = 0; i < 4; i++)
                pkt[16 + i] = dst[(3 - i) * 8 +: 8];
            if (kind == FRAME_FRAGMENT)
            begin
                if ($urandom_range(0, 1))
                    pkt[6] = {pkt[6][7:5], 5'($urandom_range(1, 31))};
                else
                    pkt[7] = 8'($urandom_range(1, 255));
            end
            seal_header(hdr);
            case (kind)
                FRAME_BAD_SUM:
                begin
                    // one flipped bit always breaks the ones-complement sum
                    idx = $urandom_range(10, hdr - 1);
                    pkt[idx] = pkt[idx] ^ (8'd1 << $urandom_range(0, 7));
                end
                FRAME_HDR_LONG:
                begin
                    cut = $urandom_range(20, hdr - 1);
                    while (pkt.size() > cut)
                        void'(pkt.pop_back());
                end
                FRAME_SHORT:
                begin
                    cut = $urandom_range(1, 19);
                    while (pkt.size() > cut)
                        void'(pkt.pop_back());
                end
                FRAME_BAD_VER:
                begin
                    do
                        b0 = 8'($urandom_range(0, 255));
                    while (b0[7:4] == IP_VERSION_4 && b0[3:0] >= MIN_IHL_WORDS);
                    pkt[0] = b0;
                end
                default:;
            endcase
        end
    endtask

    task automatic write_address(input logic [31:0] a);
        in_valid <= 1'b0;
        // the pending count is registered, so it trails the last accepted beat
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_addr   = a;
        cfg_writes++;
    endtask

    initial
    begin
        int          phase_bytes;
        int          pick;
        logic [31:0] addr;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        frame_byte   = '0;
        last         = 1'b0;
        rx_mode      = RX_ALWAYS;
        hold_request = 1'b0;
        tx_gappy     = 1'b0;
        burst_left   = 0;
        cfg_writes   = 0;
        idle_cycles  = 0;
        cur_addr     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-byte frames at both byte extremes, then one clean header
        write_address(32'h0000_0000);
        pkt.delete();
        pkt.push_back(8'h00);
        send_frame();
        pkt.delete();
        pkt.push_back(8'hFF);
        send_frame();
        build_frame(FRAME_GOOD);
        send_frame();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       addr = 32'hFFFF_FFFF;
                2:       addr = 32'h0000_0000;
                default: addr = $urandom;
            endcase
            write_address(addr);
            tx_gappy = (p % 3) != 0;
            rx_mode <= rx_mode_e'(p % 4);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 15);
                build_frame(pick <= 5 ? FRAME_GOOD : frame_kind_e'(pick - 5));
                phase_bytes += pkt.size();
                send_frame();
            end
        end

        // output held off while short frames keep coming, so the input backs up
        write_address($urandom);
        tx_gappy = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_request <= 1'b1;
        for (int f = 0; f < 12; f++)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 3))
                pkt.push_back(8'($urandom_range(0, 255)));
            send_frame();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d byte beats, %0d verdicts, %0d of 11 verdict codes, %0d errors",
                 beats_seen, verdicts_seen, $countones(verdicts_hit), check_errors);
        $display("run: %0d address writes incl. all-zero and all-ones, long output stall",
                 cfg_writes);
        if (check_errors == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
